// ----- src/bb3_pkg.sv -----
package bb3_pkg;

    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int SUM_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic            op;
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
    } pix_word_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic            frame_end;
    } res_word_t;

    // one line-store entry: two rows of the same column
    typedef struct packed {
        pix_t upper;
        pix_t middle;
    } line_t;

    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } div_sel_t;

endpackage

// ----- src/box_blur_3x3_edge_aware_top.sv -----
// Channel  Handshake              Word / data
// pix      pix_valid, pix_stall   pix_word   (op, in_red, in_green, in_blue)
// res      res_valid, res_stall   res_word   (out_red, out_green, out_blue, frame_end)
// cfg      cfg_valid, cfg_ready   cfg_index, cfg_data
//
// One pix word is taken every cycle while pix_stall is low; the line store is read at the
// accepting edge, sums are formed in the next cycle (with the write-back), and the
// rounded means of the stage-2 registers enter a four-word output queue. Reset clears
// control only; the line store is not cleared and needs no sweep. A stalled res side
// fills the queue, then holds the two stages and raises pix_stall.
module box_blur_3x3_edge_aware_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    output logic                            pix_stall,
    input  bb3_pkg::pix_word_t              pix_word,
    output logic                            res_valid,
    input  logic                            res_stall,
    output bb3_pkg::res_word_t              res_word,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bb3_pkg::*;

    localparam int AW         = $clog2(MAX_WIDTH);
    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;
    localparam int COL_W      = 10;

    localparam logic [AW-1:0] W_LAST_RST = AW'((640 > MAX_WIDTH ? MAX_WIDTH : 640) - 1);
    localparam logic [RW-1:0] H_LAST_RST = RW'((480 > MAX_HEIGHT ? MAX_HEIGHT : 480) - 1);

    // saturate a written dimension and keep it as the last index
    function automatic logic [AW-1:0] width_last(input logic [CFG_DATA_W-1:0] v);
        if (v < CFG_DATA_W'(2))
            return AW'(1);
        else if (32'(v) > 32'(MAX_WIDTH))
            return AW'(MAX_WIDTH - 1);
        else
            return AW'(32'(v) - 32'd1);
    endfunction

    function automatic logic [RW-1:0] height_last(input logic [CFG_DATA_W-1:0] v);
        if (v < CFG_DATA_W'(2))
            return RW'(1);
        else if (32'(v) > 32'(MAX_HEIGHT))
            return RW'(MAX_HEIGHT - 1);
        else
            return RW'(32'(v) - 32'd1);
    endfunction

    // one channel of a window column, the top row only where it exists
    function automatic logic [COL_W-1:0] col_sum(input logic [CH_W-1:0] t,
                                                 input logic [CH_W-1:0] m,
                                                 input logic [CH_W-1:0] b,
                                                 input logic            use_t);
        return (use_t ? COL_W'(t) : COL_W'(0)) + COL_W'(m) + COL_W'(b);
    endfunction

    // frame control
    logic [AW-1:0] w_last_reg;
    logic [RW-1:0] h_last_reg;
    logic [AW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [AW-1:0] drain_reg;
    logic          draining_reg;

    logic cfg_wr;
    logic cfg_hit;
    logic accept;
    logic is_pix;
    logic is_drn;
    logic col_end;
    logic row_end;
    logic drn_end;

    // stage 1: line store data back, sums formed, write-back
    logic          s1_valid_reg;
    logic          s1_drn_reg;
    pix_t          s1_pix_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_top_reg;
    logic          s1_out_reg;
    logic          s1_left_reg;
    logic          s1_last_reg;
    logic          s1_adv;

    // stage 2: rounded division
    logic             s2_valid_reg;
    logic [SUM_W-1:0] s2_sum_a_reg [3];
    logic [SUM_W-1:0] s2_sum_b_reg [3];
    div_sel_t         s2_sel_a_reg;
    div_sel_t         s2_sel_b_reg;
    logic             s2_two_reg;
    logic             s2_fend_reg;
    logic             s2_adv;

    // output queue
    res_word_t        fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] push_n;
    logic             pop;

    // window and drain columns
    pix_t  win_reg [6];
    line_t prev_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic          wr_en;
    line_t         rd_a;
    line_t         rd_b;
    line_t         wr_line;

    pix_t             col_px [3][3];
    logic             use_top;
    logic             use_l;
    logic             use_r;
    logic             cols3;
    logic [COL_W-1:0] csum [3][3];
    logic [SUM_W-1:0] sum_a [3];
    logic [SUM_W-1:0] sum_b [3];
    div_sel_t         sel_a;
    div_sel_t         sel_b;

    logic [CH_W-1:0] mean_a [3];
    logic [CH_W-1:0] mean_b [3];
    res_word_t       word_a;
    res_word_t       word_b;

    // ------------------------------------------------------------------
    // Intake: classify the word against the frame counters.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_hit   = (cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT);

    assign s2_adv    = s2_valid_reg && (cnt_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign s1_adv    = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign pix_stall = s1_valid_reg && !s1_adv;
    assign accept    = pix_valid && !pix_stall;

    // a pixel while draining and a drain tick mid-frame are dropped
    assign is_pix  = !pix_word.op && !draining_reg;
    assign is_drn  = pix_word.op && draining_reg;
    assign col_end = (col_reg == w_last_reg);
    assign row_end = (row_reg == h_last_reg);
    assign drn_end = (drain_reg == w_last_reg);

    assign rd_en     = accept && (is_pix || is_drn);
    assign rd_addr_a = is_drn ? drain_reg : col_reg;
    assign rd_addr_b = drain_reg + AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg   <= W_LAST_RST;
            h_last_reg   <= H_LAST_RST;
            col_reg      <= '0;
            row_reg      <= '0;
            drain_reg    <= '0;
            draining_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                w_last_reg <= width_last(cfg_data);
            end
            if (cfg_index == REG_FRAME_HEIGHT)
            begin
                h_last_reg <= height_last(cfg_data);
            end
            // restart the frame; stored rows stay
            if (cfg_hit)
            begin
                col_reg      <= '0;
                row_reg      <= '0;
                drain_reg    <= '0;
                draining_reg <= 1'b0;
            end
        end
        else if (accept && is_pix)
        begin
            if (col_end)
            begin
                col_reg <= '0;
                if (row_end)
                begin
                    row_reg      <= '0;
                    drain_reg    <= '0;
                    draining_reg <= 1'b1;
                end
                else
                begin
                    row_reg <= row_reg + RW'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + AW'(1);
            end
        end
        else if (accept && is_drn)
        begin
            if (drn_end)
            begin
                drain_reg    <= '0;
                draining_reg <= 1'b0;
            end
            else
            begin
                drain_reg <= drain_reg + AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: one entry holds both stored rows of a column.
    // ------------------------------------------------------------------
    assign wr_en   = s1_adv && !s1_drn_reg;
    assign wr_line = '{upper: rd_a.middle, middle: s1_pix_reg};

    bb3_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_en     (wr_en),
        .wr_addr   (s1_addr_reg),
        .wr_data   (wr_line),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // ------------------------------------------------------------------
    // Stage 1: column sums over the clipped window.
    // Pixel: left/middle columns from the window, right from the store plus
    // the new pixel. Drain: two rows only, left column held from the tick
    // before, middle and right from both read ports.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (s1_drn_reg)
        begin
            col_px[0][0] = '0;
            col_px[0][1] = prev_reg.upper;
            col_px[0][2] = prev_reg.middle;
            col_px[1][0] = '0;
            col_px[1][1] = rd_a.upper;
            col_px[1][2] = rd_a.middle;
            col_px[2][0] = '0;
            col_px[2][1] = rd_b.upper;
            col_px[2][2] = rd_b.middle;
        end
        else
        begin
            col_px[0][0] = win_reg[0];
            col_px[0][1] = win_reg[1];
            col_px[0][2] = win_reg[2];
            col_px[1][0] = win_reg[3];
            col_px[1][1] = win_reg[4];
            col_px[1][2] = win_reg[5];
            col_px[2][0] = rd_a.upper;
            col_px[2][1] = rd_a.middle;
            col_px[2][2] = s1_pix_reg;
        end
    end

    assign use_top = !s1_drn_reg && s1_top_reg;
    assign use_l   = s1_left_reg;
    assign use_r   = !s1_drn_reg || !s1_last_reg;
    assign cols3   = s1_drn_reg ? (s1_left_reg && !s1_last_reg) : s1_left_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                csum[c][ch] = col_sum(col_px[c][0][PIX_W-1-CH_W*ch -: CH_W],
                                      col_px[c][1][PIX_W-1-CH_W*ch -: CH_W],
                                      col_px[c][2][PIX_W-1-CH_W*ch -: CH_W],
                                      use_top);
            end
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_a[ch] = (use_l ? SUM_W'(csum[0][ch]) : SUM_W'(0))
                      + SUM_W'(csum[1][ch])
                      + (use_r ? SUM_W'(csum[2][ch]) : SUM_W'(0));
            sum_b[ch] = SUM_W'(csum[1][ch]) + SUM_W'(csum[2][ch]);
        end
    end

    // pixel count of the window: rows times columns
    always_comb
    begin
        if (use_top && cols3)
            sel_a = DIV_BY_9;
        else if (use_top || cols3)
            sel_a = DIV_BY_6;
        else
            sel_a = DIV_BY_4;
        sel_b = use_top ? DIV_BY_6 : DIV_BY_4;
    end

    // ------------------------------------------------------------------
    // Stage 2: rounded means.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < 3; g++)
    begin : g_div
        bb3_round_div u_div_a (
            .sum  (s2_sum_a_reg[g]),
            .sel  (s2_sel_a_reg),
            .mean (mean_a[g])
        );
        bb3_round_div u_div_b (
            .sum  (s2_sum_b_reg[g]),
            .sel  (s2_sel_b_reg),
            .mean (mean_b[g])
        );
    end

    assign word_a = '{out_red: mean_a[0], out_green: mean_a[1], out_blue: mean_a[2],
                      frame_end: s2_fend_reg};
    assign word_b = '{out_red: mean_b[0], out_green: mean_b[1], out_blue: mean_b[2],
                      frame_end: 1'b0};

    // ------------------------------------------------------------------
    // Output queue: up to two words in, one out per cycle while res_stall is low.
    // ------------------------------------------------------------------
    assign res_valid = (cnt_reg != '0);
    assign res_word  = fifo_reg[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;
    assign push_n    = s2_adv ? (s2_two_reg ? CNT_W'(2) : CNT_W'(1)) : CNT_W'(0);
    assign cnt_next  = cnt_reg + push_n - (pop ? CNT_W'(1) : CNT_W'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (rd_en)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            // words that give no result stop at stage 1
            if (s1_adv)
                s2_valid_reg <= s1_out_reg;
            else if (s2_adv)
                s2_valid_reg <= 1'b0;

            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_drn_reg  <= is_drn;
            s1_pix_reg  <= {pix_word.in_red, pix_word.in_green, pix_word.in_blue};
            s1_addr_reg <= col_reg;
            s1_top_reg  <= (row_reg > RW'(1));
            s1_out_reg  <= is_drn || ((row_reg != '0) && (col_reg != '0));
            s1_left_reg <= is_drn ? (drain_reg != '0) : (col_reg > AW'(1));
            s1_last_reg <= is_drn ? drn_end : col_end;
        end

        if (s1_adv)
        begin
            if (s1_drn_reg)
            begin
                prev_reg <= rd_a;
            end
            else
            begin
                // advance the window by one column
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= rd_a.upper;
                win_reg[4] <= rd_a.middle;
                win_reg[5] <= s1_pix_reg;
            end
            for (int ch = 0; ch < 3; ch++)
            begin
                s2_sum_a_reg[ch] <= sum_a[ch];
                s2_sum_b_reg[ch] <= sum_b[ch];
            end
            s2_sel_a_reg <= sel_a;
            s2_sel_b_reg <= sel_b;
            s2_two_reg   <= !s1_drn_reg && s1_last_reg;
            s2_fend_reg  <= s1_drn_reg && s1_last_reg;
        end

        if (s2_adv)
        begin
            fifo_reg[wr_ptr_reg] <= word_a;
            if (s2_two_reg)
            begin
                fifo_reg[wr_ptr_reg + PTR_W'(1)] <= word_b;
            end
        end
    end

endmodule

// ----- src/bb3_line_store.sv -----
module bb3_line_store #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic           clk,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr_a,
    input  logic [AW-1:0]  rd_addr_b,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  bb3_pkg::line_t wr_data,
    output bb3_pkg::line_t rd_data_a,
    output bb3_pkg::line_t rd_data_b
);
    import bb3_pkg::*;

    line_t mem [DEPTH];
    line_t rd_a_reg;
    line_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // forward a write that lands on the address being read at the same edge
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
            rd_b_reg <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ----- src/bb3_round_div.sv -----
module bb3_round_div (
    input  logic [bb3_pkg::SUM_W-1:0] sum,
    input  bb3_pkg::div_sel_t         sel,
    output logic [bb3_pkg::CH_W-1:0]  mean
);
    import bb3_pkg::*;

    // reciprocals scaled by 2^16, exact for every sum below 2^15
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 14;
    localparam logic [RECIP_W-1:0] RECIP_6 = 14'd10923;
    localparam logic [RECIP_W-1:0] RECIP_9 = 14'd7282;

    logic [SUM_W-1:0]         biased;
    logic [SUM_W+RECIP_W-1:0] prod;

    always_comb
    begin
        biased = sum;
        prod   = '0;
        mean   = '0;
        unique case (sel)
            DIV_BY_6:
            begin
                biased = sum + SUM_W'(3);
                prod   = (SUM_W+RECIP_W)'(biased) * (SUM_W+RECIP_W)'(RECIP_6);
                mean   = prod[RECIP_SHIFT +: CH_W];
            end
            DIV_BY_9:
            begin
                biased = sum + SUM_W'(4);
                prod   = (SUM_W+RECIP_W)'(biased) * (SUM_W+RECIP_W)'(RECIP_9);
                mean   = prod[RECIP_SHIFT +: CH_W];
            end
            default:
            begin
                biased = sum + SUM_W'(2);
                mean   = biased[2 +: CH_W];
            end
        endcase
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

// Testbench for the streaming 3x3 box blur.
//
// A predictor inside this module keeps its own line stores, window and frame
// counters. Each pix word that the block accepts is fed to it, and the
// blurred pixels it produces are queued. Every res word that leaves the block
// is compared field by field with the oldest queued pixel.
//
// Tests run in turn from one initial block:
//   test_borders_and_rounding - small frames: corners, edges, interior,
//                               half-up rounding, ignored words and unused
//                               register indexes, sizes saturated up to two
//   test_extreme_sizes        - the first rows of a widest frame and of a
//                               tallest frame, both abandoned early
//   test_random_frames        - well-formed frames of random size and content,
//                               sprinkled with stray words and aborted frames
module testbench;

    import bb3_pkg::*;

    localparam int unsigned MAX_DIM       = 1024;
    localparam int unsigned IDLE_PCT      = 21;
    localparam int unsigned NOISE_PCT     = 4;
    localparam int unsigned RANDOM_WORDS  = 450;
    localparam int unsigned WIDE_WORDS    = 1060;
    localparam int unsigned TALL_WORDS    = 40;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_LIMIT   = 5000;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // indexes with no register behind them: a write must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  pix_valid;
    logic                  pix_stall;
    pix_word_t             pix_word;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    res_word_t             res_word;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned error_count = 0;
    bit          no_idle = 1'b0;

    // predictor state
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    pix_t                  upper_line [MAX_DIM];
    pix_t                  middle_line [MAX_DIM];
    pix_t                  window [6];
    int unsigned           row_pos;
    int unsigned           col_pos;
    int unsigned           drain_pos;
    bit                    draining;
    int unsigned           sum_red;
    int unsigned           sum_green;
    int unsigned           sum_blue;
    res_word_t             blurred_due [$];

    box_blur_3x3_edge_aware_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_word  (pix_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // saturate a programmed size into the range the block supports
    function automatic int unsigned eff_dim(logic [CFG_DATA_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    function automatic void restart_frame();
        row_pos   = 0;
        col_pos   = 0;
        drain_pos = 0;
        draining  = 1'b0;
        for (int i = 0; i < 6; i++)
            window[i] = '0;
    endfunction

    function automatic void add_pix(pix_t p);
        sum_red   += p[23:16];
        sum_green += p[15:8];
        sum_blue  += p[7:0];
    endfunction

    function automatic void clear_sums();
        sum_red   = 0;
        sum_green = 0;
        sum_blue  = 0;
    endfunction

    // queue the half-up rounded mean of the current sums
    function automatic void push_blurred(int unsigned n, logic fend);
        res_word_t r;
        r.out_red   = 8'((sum_red + n / 2) / n);
        r.out_green = 8'((sum_green + n / 2) / n);
        r.out_blue  = 8'((sum_blue + n / 2) / n);
        r.frame_end = fend;
        blurred_due.push_back(r);
    endfunction

    // centre column and the arriving column of the window
    function automatic void add_near_cols(bit top, pix_t nu, pix_t nm, pix_t px);
        if (top)
            add_pix(window[3]);
        add_pix(window[4]);
        add_pix(window[5]);
        if (top)
            add_pix(nu);
        add_pix(nm);
        add_pix(px);
    endfunction

    function automatic void reg_write_effect(logic [CFG_IDX_W-1:0] idx,
                                             logic [CFG_DATA_W-1:0] val);
        if (idx == REG_FRAME_WIDTH)
        begin
            width_reg = val;
            restart_frame();
        end
        else if (idx == REG_FRAME_HEIGHT)
        begin
            height_reg = val;
            restart_frame();
        end
    endfunction

    // advance the predictor by one accepted word; returns 0 if ignored
    function automatic bit blur_step(pix_word_t w);
        int unsigned wd;
        int unsigned ht;
        int unsigned c;
        int unsigned r;
        int unsigned d;
        int unsigned rows;
        int unsigned n;
        pix_t        px;
        pix_t        nu;
        pix_t        nm;
        bit          top;

        wd = eff_dim(width_reg);
        ht = eff_dim(height_reg);

        if (w.op == OP_DRAIN)
        begin
            d = drain_pos;
            if (!draining || d >= wd)
                return 1'b0;
            clear_sums();
            n = 2;
            if (d >= 1)
            begin
                add_pix(upper_line[d - 1]);
                add_pix(middle_line[d - 1]);
                n += 2;
            end
            add_pix(upper_line[d]);
            add_pix(middle_line[d]);
            if (d + 1 < wd)
            begin
                add_pix(upper_line[d + 1]);
                add_pix(middle_line[d + 1]);
                n += 2;
            end
            if (d == wd - 1)
            begin
                push_blurred(n, 1'b1);
                restart_frame();
            end
            else
            begin
                push_blurred(n, 1'b0);
                drain_pos = d + 1;
            end
            return 1'b1;
        end

        if (draining)
            return 1'b0;

        c = col_pos;
        r = row_pos;
        if (c >= wd)
            c = 0;
        px   = {w.in_red, w.in_green, w.in_blue};
        nu   = upper_line[c];
        nm   = middle_line[c];
        top  = (r >= 2);
        rows = top ? 3 : 2;

        // the word completes the window of the pixel one row up, one column left
        if (r >= 1 && c >= 1)
        begin
            clear_sums();
            n = 2 * rows;
            if (c >= 2)
            begin
                if (top)
                    add_pix(window[0]);
                add_pix(window[1]);
                add_pix(window[2]);
                n += rows;
            end
            add_near_cols(top, nu, nm, px);
            push_blurred(n, 1'b0);
            // last column of the row: its window has no right column
            if (c == wd - 1)
            begin
                clear_sums();
                add_near_cols(top, nu, nm, px);
                push_blurred(2 * rows, 1'b0);
            end
        end

        for (int i = 0; i < 3; i++)
            window[i] = window[i + 3];
        window[3]      = nu;
        window[4]      = nm;
        window[5]      = px;
        upper_line[c]  = nm;
        middle_line[c] = px;

        c++;
        if (c >= wd)
        begin
            c = 0;
            r++;
            if (r >= ht)
            begin
                draining  = 1'b1;
                drain_pos = 0;
            end
        end
        col_pos = c;
        row_pos = r;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Drivers and checker
    // ------------------------------------------------------------------

    task automatic report_error(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic pix_word_t random_word(logic op);
        pix_word_t w;
        w.op       = op;
        w.in_red   = 8'($urandom_range(0, 255));
        w.in_green = 8'($urandom_range(0, 255));
        w.in_blue  = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // Offer one word, hold it while stalled, then feed it to the predictor.
    // Valid drops only on an idle cycle, so back-to-back words keep it high.
    task automatic send_word(input pix_word_t w, output bit taken);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_word  <= w;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        taken = blur_step(w);
    endtask

    // Write one register; keep valid high unless this is the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_write_effect(idx, val);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for every queued pixel, then let the pipeline empty.
    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        pix_valid <= 1'b0;
        @(posedge clk);
        while (blurred_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (blurred_due.size() != 0)
        begin
            report_error($sformatf("%0d blurred pixels never arrived",
                                   blurred_due.size()));
            blurred_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w, 1'b0);
        write_reg(REG_FRAME_HEIGHT, h, 1'b1);
    endtask

    // Send one frame (pixels, then drain ticks) with random content and a few
    // stray words; stop early once `limit` words have been taken.
    task automatic run_frame(input int unsigned limit, output int unsigned consumed);
        int unsigned full;
        logic        op;
        bit          taken;
        full     = eff_dim(width_reg) * (eff_dim(height_reg) + 1);
        consumed = 0;
        while (consumed < full && consumed < limit)
        begin
            op = draining ? OP_DRAIN : OP_PIXEL;
            if ($urandom_range(99) < NOISE_PCT)
                op = !op;
            send_word(random_word(op), taken);
            if (taken)
                consumed++;
        end
    endtask

    // Compare each accepted res word with the oldest queued pixel and drive
    // the res stall. The stall read here is the one the block saw at this edge.
    always @(posedge clk)
    begin : res_check
        res_word_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (blurred_due.size() == 0)
                report_error($sformatf("unexpected res word %h", res_word));
            else
            begin
                want = blurred_due.pop_front();
                if (res_word.out_red !== want.out_red)
                    report_error($sformatf("out_red %h, want %h",
                                           res_word.out_red, want.out_red));
                if (res_word.out_green !== want.out_green)
                    report_error($sformatf("out_green %h, want %h",
                                           res_word.out_green, want.out_green));
                if (res_word.out_blue !== want.out_blue)
                    report_error($sformatf("out_blue %h, want %h",
                                           res_word.out_blue, want.out_blue));
                if (res_word.frame_end !== want.frame_end)
                    report_error($sformatf("frame_end %b, want %b",
                                           res_word.frame_end, want.frame_end));
            end
        end
        res_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // 3x3 frame: every pixel class (corner, edge, interior) and uneven sums
    // for half-up rounding; a stray drain tick mid-frame, a stray pixel while
    // draining, and writes to the unused indexes that must not restart the
    // frame. Then a 2x2 frame from sizes below range.
    task automatic test_borders_and_rounding();
        pix_word_t w;
        bit        taken;

        set_frame(11'd3, 11'd3);
        for (int i = 0; i < 9; i++)
        begin
            if (i == 2)
                send_word(random_word(OP_DRAIN), taken);
            if (i == 4)
            begin
                wait_idle();
                write_reg(REG_SPARE_2, 11'h7FF, 1'b0);
                write_reg(REG_SPARE_3, 11'h000, 1'b1);
            end
            w.op       = OP_PIXEL;
            w.in_red   = (i % 2 == 1) ? 8'hFF : 8'h00;
            w.in_green = (i % 3 == 0) ? 8'hFF : 8'h01;
            w.in_blue  = 8'(i * 37);
            send_word(w, taken);
        end
        send_word(random_word(OP_PIXEL), taken);
        repeat (3) send_word(random_word(OP_DRAIN), taken);

        // width 0 and height 1 saturate up to 2
        set_frame(11'd0, 11'd1);
        for (int i = 0; i < 4; i++)
        begin
            w.op       = OP_PIXEL;
            w.in_red   = (i == 1) ? 8'h00 : 8'hFF;
            w.in_green = (i >= 2) ? 8'hFF : 8'h00;
            w.in_blue  = (i == 0) ? 8'hFF : 8'h01;
            send_word(w, taken);
        end
        repeat (2) send_word(random_word(OP_DRAIN), taken);
    endtask

    // widest frame (width above range saturates to the maximum): a full first
    // row and the start of the second, so the row wraps at the maximum width;
    // then the first rows of the tallest frame at the smallest width
    task automatic test_extreme_sizes();
        int unsigned got;
        set_frame(11'd2047, 11'd2);
        run_frame(WIDE_WORDS, got);
        set_frame(11'd2, 11'd1024);
        run_frame(TALL_WORDS, got);
    endtask

    task automatic test_random_frames();
        int unsigned done_words;
        int unsigned got;
        int unsigned pick;
        int unsigned w;
        int unsigned h;
        int unsigned limit;

        done_words = 0;
        while (done_words < RANDOM_WORDS)
        begin
            // hold one long stretch with no idling on either side
            no_idle = (done_words >= 100 && done_words < 300);
            pick    = $urandom_range(99);
            if (pick < 8)
            begin
                // out-of-range or huge sizes: send a short piece, then abandon it
                case ($urandom_range(2))
                    0:       w = 0;
                    1:       w = 1;
                    default: w = $urandom_range(1024, 2047);
                endcase
                h = $urandom_range(0, 2047);
                set_frame(11'(w), 11'(h));
                run_frame($urandom_range(5, 40), got);
                done_words += got;
            end
            else
            begin
                w = (pick < 20) ? $urandom_range(13, 48) : $urandom_range(2, 12);
                h = $urandom_range(2, 6);
                set_frame(11'(w), 11'(h));
                repeat ($urandom_range(1, 3))
                begin
                    limit = ($urandom_range(99) < 5) ? $urandom_range(1, w * h)
                                                     : 32'hFFFF_FFFF;
                    run_frame(limit, got);
                    done_words += got;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        pix_valid = 1'b0;
        pix_word  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;

        width_reg  = 11'd640;
        height_reg = 11'd480;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        restart_frame();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_borders_and_rounding();
        test_extreme_sizes();
        test_random_frames();
        wait_idle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // guard against a hung handshake
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
